[design/lpl_pkg.sv]
// Shared types and constants for the lookahead peak limiter.
package lpl_pkg;

    // Field and register widths.
    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 24;
    localparam int COEF_W   = 24;
    localparam int DLY_W    = 10;
    localparam int CFG_W    = 24;
    localparam int CFG_AW   = 2;

    // Delay line geometry.
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = 10;

    // Divider geometry: quotient bits of ceiling * 2^23 / envelope.
    localparam int QUOT_W = 23;
    localparam int CNT_W  = 5;

    // Shared multiplier operand and product widths.
    localparam int MUL_AW = 25;
    localparam int MUL_BW = 24;
    localparam int PROD_W = 49;

    localparam logic [GAIN_W-1:0]   UNITY_GAIN = 24'h800000;
    localparam logic [MUL_AW-1:0]   COEFF_ONE  = 25'h1000000;
    localparam logic [SAMPLE_W-1:0] MAX_POS    = 24'h7FFFFF;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] CEILING_RST = 24'd8388608;
    localparam logic [COEF_W-1:0] RELEASE_RST = 24'd16776866;
    localparam logic [DLY_W-1:0]  DELAY_RST   = 10'd64;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_CEILING = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_RELEASE = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_DELAY   = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MEM,
        S_PEAK,
        S_ENV1,
        S_ENV2,
        S_ENV3,
        S_GAIN,
        S_DIV,
        S_OUT1,
        S_OUT2
    } t_state;

    // Operand selection of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_ENV,
        MUL_PEAK,
        MUL_OUT
    } t_mul_sel;

    // Divider status toward the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[design/lpl_div.sv]
// Restoring divider, one quotient bit per cycle: floor(hi * 2^23 / divisor).
module lpl_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lpl_pkg::GAIN_W-1:0]   i_dividend_hi,
    input  logic [lpl_pkg::SAMPLE_W-1:0] i_divisor,
    output lpl_pkg::t_div_stat           o_stat,
    output logic [lpl_pkg::QUOT_W-1:0]   o_quot
);
    import lpl_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [SAMPLE_W-1:0] r_rem;
    logic [SAMPLE_W-1:0] r_dvs;
    logic [QUOT_W-1:0]   r_quot;

    logic [SAMPLE_W:0]   c_trial;
    logic [SAMPLE_W:0]   c_diff;
    logic                c_fits;

    // One compare and subtract step on the shifted remainder.
    always_comb begin
        c_trial = {r_rem, 1'b0};
        c_diff  = c_trial - {1'b0, r_dvs};
        c_fits  = (c_trial >= {1'b0, r_dvs});
    end

    // Control: step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the remainder starts at the dividend's high part, below the divisor.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend_hi;
            r_dvs  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= c_fits ? c_diff[SAMPLE_W-1:0] : c_trial[SAMPLE_W-1:0];
            r_quot <= {r_quot[QUOT_W-2:0], c_fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

[design/lookahead_peak_limiter.sv]
// Top level of the lookahead peak limiter: delay line, envelope, gain and output.
//
// Channel   Dir  Handshake                          Payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata[23:0] sample_in
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata[23:0] sample_out, [47:24] applied_gain
// cfg       in   i_cfg_we (no wait, no read-back)   i_cfg_addr index, i_cfg_wdata value
//
// An item occupies the block from its acceptance cycle through the cycle that loads the
// output register, passing MEM, PEAK and ENV1, then ENV2 and ENV3 when the envelope releases,
// GAIN, then DIV when the gain must be divided out, and OUT1 and OUT2; the 23-step restoring
// divider, with its done cycle, makes the divided path the longer one.
// One item is in work at a time; the next is accepted as soon as the previous
// one sits in the output register, even if that result is not yet taken.
// Reset is synchronous; the delay line is not cleared, a fill mark makes
// unwritten entries read as zero. A stalled output holds the sequencer in its last state.
module lookahead_peak_limiter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [23:0]                   i_s_axis_tdata,   // [23:0] sample_in
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [47:0]                   o_m_axis_tdata,   // [23:0] sample_out, [47:24] applied_gain
    input  logic                          i_cfg_we,
    input  logic [lpl_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [lpl_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import lpl_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0]    r_ceiling;
    logic [COEF_W-1:0]   r_release;
    logic [DLY_W-1:0]    r_delay;

    // Sequencer.
    t_state              r_state;
    t_state              n_state;

    // Control outputs of the sequencer.
    logic                c_ready;
    logic                c_mem_en;
    logic                c_div_start;
    logic                c_out_load;
    t_mul_sel            c_mul_sel;

    // Delay line and its pointers.
    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0]   r_wp;
    logic                r_full;
    logic [ADDR_W-1:0]   c_rp;

    // Datapath registers.
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_rdata;
    logic                r_bypass;
    logic                r_valid;
    logic                r_neg;
    logic [SAMPLE_W-1:0] r_peak;
    logic [SAMPLE_W-1:0] r_env;
    logic [GAIN_W-1:0]   r_gain;
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]   r_hold;

    // Output register.
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic [GAIN_W-1:0]   r_out_gain;

    // Combinational helpers.
    logic [SAMPLE_W-1:0] c_delayed;
    logic [MUL_AW-1:0]   c_mul_a;
    logic [MUL_BW-1:0]   c_mul_b;
    logic [PROD_W-1:0]   c_mul_p;
    logic [PROD_W-1:0]   c_env_sum;
    logic [PROD_W-1:0]   c_rounded;
    logic [SAMPLE_W-1:0] c_mag;
    logic [SAMPLE_W-1:0] c_result;
    logic                c_out_free;

    t_div_stat           w_div_stat;
    logic [QUOT_W-1:0]   w_quot;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling <= CEILING_RST;
            r_release <= RELEASE_RST;
            r_delay   <= DELAY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CEILING: r_ceiling <= i_cfg_wdata;
                CFG_RELEASE: r_release <= i_cfg_wdata[COEF_W-1:0];
                CFG_DELAY:   r_delay   <= i_cfg_wdata[DLY_W-1:0];
                default: ;
            endcase
        end
    end

    assign c_out_free = !r_out_valid || i_m_axis_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_s_axis_tvalid) n_state = S_MEM;
            S_MEM:  n_state = S_PEAK;
            S_PEAK: n_state = S_ENV1;
            S_ENV1: n_state = (r_peak > r_env) ? S_GAIN : S_ENV2;
            S_ENV2: n_state = S_ENV3;
            S_ENV3: n_state = S_GAIN;
            S_GAIN: n_state = ({1'b0, r_env} > {1'b0, r_ceiling}) ? S_DIV : S_OUT1;
            S_DIV:  if (w_div_stat.done) n_state = S_OUT1;
            S_OUT1: n_state = S_OUT2;
            S_OUT2: if (c_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        c_ready     = 1'b0;
        c_mem_en    = 1'b0;
        c_div_start = 1'b0;
        c_out_load  = 1'b0;
        c_mul_sel   = MUL_ENV;
        unique case (r_state)
            S_IDLE: c_ready = 1'b1;
            S_MEM:  c_mem_en = 1'b1;
            S_ENV1: c_mul_sel = MUL_ENV;
            S_ENV2: c_mul_sel = MUL_PEAK;
            S_GAIN: c_div_start = ({1'b0, r_env} > {1'b0, r_ceiling});
            S_OUT1: c_mul_sel = MUL_OUT;
            S_OUT2: c_out_load = c_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_axis_tready = c_ready;

    // Delay line: write the new sample and read the delayed one in the same cycle.
    assign c_rp = r_wp - r_delay[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (c_mem_en) begin
            mem[r_wp] <= r_sample;
            r_rdata   <= mem[c_rp];
        end
    end

    // Write pointer and fill mark; entries past the pointer are unwritten until it wraps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_full <= 1'b0;
        end else if (c_mem_en) begin
            r_wp <= r_wp + 1'b1;
            if (r_wp == ADDR_W'(DEPTH - 1)) begin
                r_full <= 1'b1;
            end
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        case (c_mul_sel)
            MUL_ENV: begin
                c_mul_a = {1'b0, r_release};
                c_mul_b = r_env;
            end
            MUL_PEAK: begin
                c_mul_a = COEFF_ONE - {1'b0, r_release};
                c_mul_b = r_peak;
            end
            MUL_OUT: begin
                c_mul_a = {1'b0, r_peak};
                c_mul_b = r_gain;
            end
            default: begin
                c_mul_a = '0;
                c_mul_b = '0;
            end
        endcase
        c_mul_p = PROD_W'(c_mul_a) * PROD_W'(c_mul_b);
    end

    // Delayed sample: straight through at zero delay, zero from an unwritten entry.
    always_comb begin
        if (r_bypass) begin
            c_delayed = r_sample;
        end else if (r_valid) begin
            c_delayed = r_rdata;
        end else begin
            c_delayed = '0;
        end
    end

    // Envelope decay sum and output rounding.
    assign c_env_sum = r_prod + r_hold;
    assign c_rounded = r_prod + PROD_W'(1 << 22);
    assign c_mag     = c_rounded[46:23];

    // Saturate: only a positive full-scale result overflows.
    always_comb begin
        if (!r_neg && c_mag[SAMPLE_W-1]) begin
            c_result = MAX_POS;
        end else if (r_neg) begin
            c_result = -c_mag;
        end else begin
            c_result = c_mag;
        end
    end

    // Datapath steps under the sequencer.
    always_ff @(posedge i_clk) begin
        if (c_ready && i_s_axis_tvalid) begin
            r_sample <= i_s_axis_tdata;
        end
        if (c_mem_en) begin
            r_bypass <= (r_delay == '0);
            r_valid  <= r_full || (c_rp < r_wp);
        end
        case (r_state)
            S_PEAK: begin
                r_neg  <= c_delayed[SAMPLE_W-1];
                r_peak <= c_delayed[SAMPLE_W-1] ? -c_delayed : c_delayed;
            end
            S_ENV1: begin
                r_prod <= c_mul_p;
            end
            S_ENV2: begin
                r_hold <= r_prod;
                r_prod <= c_mul_p;
            end
            S_GAIN: begin
                if (!c_div_start) begin
                    r_gain <= UNITY_GAIN;
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    r_gain <= {1'b0, w_quot};
                end
            end
            S_OUT1: begin
                r_prod <= c_mul_p;
            end
            default: ;
        endcase
    end

    // Envelope state: instant attack, one-pole release.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env <= '0;
        end else if (r_state == S_ENV1 && r_peak > r_env) begin
            r_env <= r_peak;
        end else if (r_state == S_ENV3) begin
            r_env <= c_env_sum[47:24];
        end
    end

    // Gain divider.
    lpl_div u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (c_div_start),
        .i_dividend_hi (r_ceiling),
        .i_divisor     (r_env),
        .o_stat        (w_div_stat),
        .o_quot        (w_quot)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_out_load) begin
            r_out_sample <= c_result;
            r_out_gain   <= r_gain;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_gain, r_out_sample};

endmodule

[test/lookahead_peak_limiter_tb.sv]
// Self-checking testbench for the lookahead peak limiter: directed and random audio items.
`timescale 1ns / 1ps

module lookahead_peak_limiter_tb;
    import lpl_pkg::*;

    // Register index that maps to no register; writes to it must be ignored.
    localparam logic [CFG_AW-1:0] CFG_UNUSED = 2'd3;

    // Cycles without any accepted item before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Quiet cycles after the last result, above the longest divide latency.
    localparam int SETTLE_CYCLES  = 48;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 100;

    // One limited output item as the block packs it on the master side.
    typedef struct packed {
        logic [GAIN_W-1:0]   gain;
        logic [SAMPLE_W-1:0] level;
    } t_limited;

    // Tracks the limiter state and holds the limited samples still to come.
    class limiter_scoreboard;
        logic [SAMPLE_W-1:0] ring [DEPTH];
        logic [ADDR_W-1:0]   wr_ptr;
        longint unsigned     envelope;
        logic [CFG_W-1:0]    ceiling;
        logic [COEF_W-1:0]   rel_coeff;
        logic [DLY_W-1:0]    lookahead;
        t_limited            limited_q [$];
        int                  errors;

        function new();
            foreach (ring[i]) ring[i] = '0;
            wr_ptr    = '0;
            envelope  = 0;
            ceiling   = CEILING_RST;
            rel_coeff = RELEASE_RST;
            lookahead = DELAY_RST;
            errors    = 0;
        endfunction

        function int pending();
            return limited_q.size();
        endfunction

        task report(input string msg);
            errors++;
            $display("%0t ns: %s", $time, msg);
        endtask

        // Mirror a register write; an unknown index leaves everything alone.
        function void note_config(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
            case (idx)
                CFG_CEILING: ceiling   = val;
                CFG_RELEASE: rel_coeff = val;
                CFG_DELAY:   lookahead = val[DLY_W-1:0];
                default: ;
            endcase
        endfunction

        // Run one accepted sample through delay line, envelope, gain and output stage.
        function void note_sample(input logic [SAMPLE_W-1:0] smp);
            logic [ADDR_W-1:0] rd_ptr;
            longint            dv;
            longint            res;
            longint unsigned   mag;
            longint unsigned   c;
            longint unsigned   ceil_s;
            longint unsigned   gain;
            longint unsigned   r;
            t_limited          want;

            ring[wr_ptr] = smp;
            rd_ptr = wr_ptr - lookahead;
            wr_ptr = wr_ptr + 1'b1;

            dv = longint'(signed'(ring[rd_ptr]));
            if (dv < 0)
                mag = -dv;
            else
                mag = dv;

            // Instant attack, one-pole release toward the current magnitude.
            if (mag > envelope) begin
                envelope = mag;
            end else begin
                c = 64'(rel_coeff);
                envelope = (c * envelope + (longint'(COEFF_ONE) - c) * mag) >> 24;
            end

            ceil_s = 64'(ceiling);
            if (envelope > ceil_s)
                gain = (ceil_s << 23) / envelope;
            else
                gain = 64'(UNITY_GAIN);

            // Round half away from zero on the magnitude, then restore the sign.
            r = (mag * gain + (64'd1 << 22)) >> 23;
            res = (dv < 0) ? -longint'(r) : longint'(r);
            if (res > longint'(MAX_POS))
                res = longint'(MAX_POS);
            if (res < -longint'(MAX_POS) - 1)
                res = -longint'(MAX_POS) - 1;

            want.level = res[SAMPLE_W-1:0];
            want.gain  = gain[GAIN_W-1:0];
            limited_q.push_back(want);
        endfunction

        // Compare one accepted output item against the oldest prediction.
        task check_result(input logic [47:0] tdata);
            t_limited want;
            if (limited_q.size() == 0) begin
                report($sformatf("output %h arrived with nothing predicted", tdata));
            end else begin
                want = limited_q.pop_front();
                if (tdata[23:0] !== want.level)
                    report($sformatf("sample_out %h, predicted %h", tdata[23:0], want.level));
                if (tdata[47:24] !== want.gain)
                    report($sformatf("applied_gain %h, predicted %h", tdata[47:24], want.gain));
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [23:0]         i_s_axis_tdata;   // [23:0] sample_in
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [47:0]         o_m_axis_tdata;   // [23:0] sample_out, [47:24] applied_gain
    logic                i_cfg_we;
    logic [CFG_AW-1:0]   i_cfg_addr;
    logic [CFG_W-1:0]    i_cfg_wdata;

    limiter_scoreboard   sb;
    bit                  calm;
    int                  idle_cycles;

    lookahead_peak_limiter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Output-side ready with random stall bursts, steady once the run turns calm.
    initial begin
        int stall_left;
        stall_left = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (calm) begin
                i_m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 7) == 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Check every item the block hands over.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata);
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("lookahead_peak_limiter: mismatch");
            $finish;
        end
    end

    // Present one sample and hold it until accepted; valid stays high on return.
    task send_item(input logic [SAMPLE_W-1:0] smp);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= smp;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_sample(smp);
    endtask

    task pause_sender(input int cycles);
        i_s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stop sending and wait until every predicted item is out and the block is quiet.
    task drain_block();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_cfg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.note_config(idx, val);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Ceiling choices lean toward values below typical peaks so the divider works.
    function logic [CFG_W-1:0] pick_ceiling();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CEILING_RST;
            2:       return 24'hFFFFFF;
            3:       return CFG_W'($urandom_range(0, 24'hFFFFFF));
            default: return CFG_W'($urandom_range(24'h040000, 24'h7FFFFF));
        endcase
    endfunction

    function logic [COEF_W-1:0] pick_release();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 24'hFFFFFF;
            2:       return RELEASE_RST;
            3:       return COEF_W'($urandom_range(24'hF00000, 24'hFFFFFF));
            default: return COEF_W'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    // Short delays make fresh samples show up quickly; the extremes still occur.
    function logic [CFG_W-1:0] pick_delay();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 24'd1023;
            2:       return CFG_W'($urandom_range(0, 1023));
            default: return CFG_W'($urandom_range(0, 15));
        endcase
    endfunction

    // Audio-like mix: full-range noise, full-scale peaks, loud band and quiet tails.
    function logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] mag;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return SAMPLE_W'($urandom_range(0, 24'hFFFFFF));
            4:          return 24'h7FFFFF;
            5:          return 24'h800000;
            6, 7: begin
                mag = SAMPLE_W'($urandom_range(24'h200000, 24'h7FFFFF));
                return $urandom_range(0, 1) ? -mag : mag;
            end
            default: begin
                mag = SAMPLE_W'($urandom_range(0, 255));
                return $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
    endfunction

    initial begin
        sb              = new();
        calm            = 1'b0;
        idle_cycles     = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = CFG_CEILING;
        i_cfg_wdata     = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: the delayed read still hits unwritten entries, which read as zero.
        send_item(24'h7FFFFF);
        send_item(24'h800000);
        drain_block();

        // Zero delay passes the current sample straight through at unity gain.
        write_cfg(CFG_DELAY, '0);
        send_item(24'h7FFFFF);
        send_item(24'h800000);
        send_item(24'h000000);
        send_item(24'h000001);
        send_item(24'hFFFFFF);
        drain_block();

        // Half-scale ceiling with the envelope following the magnitude directly.
        write_cfg(CFG_CEILING, 24'h400000);
        write_cfg(CFG_RELEASE, '0);
        send_item(24'h7FFFFF);
        send_item(24'h800000);
        send_item(24'h200000);
        send_item(24'hA00000);
        drain_block();

        // Zero ceiling mutes everything once the envelope is non-zero.
        write_cfg(CFG_CEILING, '0);
        send_item(24'h123456);
        send_item(24'h000000);
        send_item(24'hFEDCBA);
        drain_block();

        // Ceiling above full scale, slowest release, longest delay, ignored index.
        write_cfg(CFG_CEILING, 24'hFFFFFF);
        write_cfg(CFG_RELEASE, 24'hFFFFFF);
        write_cfg(CFG_DELAY, 24'd1023);
        write_cfg(CFG_UNUSED, 24'h000005);
        send_item(24'h800000);
        send_item(24'h7FFFFF);
        drain_block();

        // Delay moved while the ring holds earlier samples.
        write_cfg(CFG_CEILING, 24'h300000);
        write_cfg(CFG_DELAY, 24'd5);
        send_item(24'h654321);
        send_item(24'h9ABCDE);
        send_item(24'h000010);
        drain_block();

        // Random phases, each of which may draw fresh settings; the last one runs without idling.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if ($urandom_range(0, 3) != 0) write_cfg(CFG_CEILING, pick_ceiling());
            if ($urandom_range(0, 3) != 0) write_cfg(CFG_RELEASE, pick_release());
            if ($urandom_range(0, 3) != 0) write_cfg(CFG_DELAY, pick_delay());
            if ($urandom_range(0, 5) == 0)
                write_cfg(CFG_UNUSED, CFG_W'($urandom_range(0, 24'hFFFFFF)));
            if (ph == RANDOM_PHASES - 1) calm = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(pick_sample());
                if (!calm) begin
                    if ($urandom_range(0, 149) == 0)
                        drain_block();
                    else if ($urandom_range(0, 7) == 0)
                        pause_sender($urandom_range(1, 6));
                end
            end
            drain_block();
        end

        if (sb.pending() != 0)
            sb.report($sformatf("%0d predicted items never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("lookahead_peak_limiter: match");
        else
            $display("lookahead_peak_limiter: mismatch");
        $finish;
    end

endmodule

[files.f]
design/lpl_pkg.sv
design/lpl_div.sv
design/lookahead_peak_limiter.sv
test/lookahead_peak_limiter_tb.sv
